### rtl/htks_pkg.sv
// Package for the hashed top-k selector: sizes, hash constants, state codes.
// Used by htks_hash, htks_ram users and hashed_top_k_selector_top.
package htks_pkg;

    localparam int CAPACITY  = 8192;
    localparam int MASK_BITS = 30;
    localparam int KEY_W     = 64;
    localparam int SEED_W    = 63;
    localparam int KEEP_W    = 14;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int SIZE_W    = ADDR_W + 1;
    localparam int ENTRY_W   = KEY_W + MASK_BITS;

    localparam logic [KEY_W-1:0] MIX_ADD  = 64'h9e3779b97f4a7c15;
    localparam logic [KEY_W-1:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
    localparam logic [KEY_W-1:0] MIX_MUL2 = 64'h94d049bb133111eb;

    localparam logic [SEED_W-1:0] SEED_RESET = 63'h4245422842334245;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 14'd8192;

    localparam logic CFG_SEED = 1'b0;
    localparam logic CFG_KEEP = 1'b1;

    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_POP   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HASH,
        ST_SU_RD,
        ST_SU_CMP,
        ST_SD_RDL,
        ST_SD_RDR,
        ST_SD_CMP,
        ST_EMIT,
        ST_POP_RD,
        ST_POP_LAST
    } t_state;

    function automatic logic [SIZE_W-1:0] limit_of(input logic [KEEP_W-1:0] k);
        logic [SIZE_W-1:0] lim;
        if (k == '0) begin
            lim = SIZE_W'(1);
        end else if (32'(k) > CAPACITY) begin
            lim = SIZE_W'(CAPACITY);
        end else begin
            lim = SIZE_W'(k);
        end
        return lim;
    endfunction

endpackage

### rtl/hashed_top_k_selector_top.sv
// Top level of the hashed top-k selector: max-heap held in one RAM.
// Depends on htks_pkg, htks_ram, htks_hash.
//
//  channel | signals                                         | direction
//  in      | i_in_valid o_in_stall i_operation i_mask        | item in
//  out     | o_out_valid i_out_stall o_result_key/mask o_was_empty | item out
//  cfg     | i_cfg_valid o_cfg_ready i_cfg_index i_cfg_data  | register write
//
// An offer hashes its key on the shared multiplier, then sifts up through states
// SU_RD and SU_CMP per heap level, or down through SD_RDL, SD_RDR, SD_CMP (up to 13 levels).
// A pop passes EMIT, POP_RD and POP_LAST, then sifts down the same way.
// The RAM's registered read data sets the per-level cost.
// Reset empties the heap at once; no clearing pass. An output stall holds a
// pop before its result is loaded; offers proceed while a result waits.
module hashed_top_k_selector_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_operation,
    input  logic [htks_pkg::MASK_BITS-1:0] i_mask,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [htks_pkg::KEY_W-1:0]     o_result_key,
    output logic [htks_pkg::MASK_BITS-1:0] o_result_mask,
    output logic                          o_was_empty,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [htks_pkg::SEED_W-1:0]    i_cfg_data
);

    localparam int AW = htks_pkg::ADDR_W;
    localparam int SW = htks_pkg::SIZE_W;
    localparam int EW = htks_pkg::ENTRY_W;

    htks_pkg::t_state r_state, n_state;

    logic [htks_pkg::SEED_W-1:0] r_seed;
    logic [htks_pkg::KEEP_W-1:0] r_keep;
    logic [SW-1:0]  r_size, n_size;
    logic [AW-1:0]  r_pos, n_pos;
    logic [EW-1:0]  r_ent, n_ent;
    logic [EW-1:0]  r_child, n_child;
    logic [EW-1:0]  r_root;
    logic [htks_pkg::MASK_BITS-1:0] r_mask_in;
    logic           r_empty, n_empty;
    logic           r_out_valid, n_out_valid;
    logic [htks_pkg::KEY_W-1:0]     r_out_key, n_out_key;
    logic [htks_pkg::MASK_BITS-1:0] r_out_mask, n_out_mask;
    logic           r_out_empty, n_out_empty;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [EW-1:0]  ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [EW-1:0]  ram_rdata;

    logic           hash_start;
    logic           hash_done;
    logic [htks_pkg::KEY_W-1:0] hash_key;

    logic           in_acc;
    logic           slot_free;
    logic [SW-1:0]  left;
    logic [SW:0]    right;
    logic           right_ok;
    logic [AW-1:0]  parent;
    logic [EW-1:0]  big;
    logic [AW-1:0]  big_addr;
    logic [EW-1:0]  new_ent;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign slot_free = !r_out_valid || !i_out_stall;
    assign left      = {r_pos, 1'b1};
    assign right     = {1'b0, left} + (SW+1)'(1);
    assign right_ok  = right < {1'b0, r_size};
    assign parent    = AW'((r_pos - AW'(1)) >> 1);
    assign new_ent   = {hash_key, r_mask_in};
    assign hash_start = in_acc && (i_operation == htks_pkg::OP_OFFER);

    htks_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_value (htks_pkg::KEY_W'(r_seed) ^ htks_pkg::KEY_W'(i_mask)),
        .o_done  (hash_done),
        .o_key   (hash_key)
    );

    htks_ram #(.WIDTH(EW), .DEPTH(htks_pkg::CAPACITY)) u_heap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_pos       = r_pos;
        n_ent       = r_ent;
        n_child     = r_child;
        n_empty     = r_empty;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_key   = r_out_key;
        n_out_mask  = r_out_mask;
        n_out_empty = r_out_empty;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = r_ent;
        ram_raddr   = left[AW-1:0];
        big         = r_child;
        big_addr    = left[AW-1:0];
        o_in_stall  = (r_state != htks_pkg::ST_IDLE);

        unique case (r_state)
            htks_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_operation == htks_pkg::OP_OFFER) begin
                        n_state = htks_pkg::ST_HASH;
                    end else begin
                        n_empty = (r_size == '0);
                        n_state = htks_pkg::ST_EMIT;
                    end
                end
            end
            htks_pkg::ST_HASH: begin
                if (hash_done) begin
                    n_ent = new_ent;
                    if (r_size < htks_pkg::limit_of(r_keep)) begin
                        n_pos   = r_size[AW-1:0];
                        n_size  = r_size + SW'(1);
                        n_state = htks_pkg::ST_SU_RD;
                    end else if (new_ent < r_root) begin
                        n_pos   = '0;
                        n_state = htks_pkg::ST_SD_RDL;
                    end else begin
                        n_state = htks_pkg::ST_IDLE;
                    end
                end
            end
            htks_pkg::ST_SU_RD: begin
                ram_raddr = parent;
                if (r_pos == '0) begin
                    ram_we  = 1'b1;
                    n_state = htks_pkg::ST_IDLE;
                end else begin
                    n_state = htks_pkg::ST_SU_CMP;
                end
            end
            htks_pkg::ST_SU_CMP: begin
                ram_we = 1'b1;
                if (ram_rdata < r_ent) begin
                    ram_wdata = ram_rdata;
                    n_pos     = parent;
                    n_state   = htks_pkg::ST_SU_RD;
                end else begin
                    n_state = htks_pkg::ST_IDLE;
                end
            end
            htks_pkg::ST_SD_RDL: begin
                if (left >= r_size) begin
                    ram_we  = 1'b1;
                    n_state = htks_pkg::ST_IDLE;
                end else begin
                    n_state = htks_pkg::ST_SD_RDR;
                end
            end
            htks_pkg::ST_SD_RDR: begin
                ram_raddr = right[AW-1:0];
                n_child   = ram_rdata;
                n_state   = htks_pkg::ST_SD_CMP;
            end
            htks_pkg::ST_SD_CMP: begin
                if (right_ok && (r_child < ram_rdata)) begin
                    big      = ram_rdata;
                    big_addr = right[AW-1:0];
                end
                ram_we = 1'b1;
                if (r_ent < big) begin
                    ram_wdata = big;
                    n_pos     = big_addr;
                    n_state   = htks_pkg::ST_SD_RDL;
                end else begin
                    n_state = htks_pkg::ST_IDLE;
                end
            end
            htks_pkg::ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_empty = r_empty;
                    if (r_empty) begin
                        n_out_key  = '0;
                        n_out_mask = '0;
                        n_state    = htks_pkg::ST_IDLE;
                    end else begin
                        n_out_key  = r_root[EW-1:htks_pkg::MASK_BITS];
                        n_out_mask = r_root[htks_pkg::MASK_BITS-1:0];
                        n_size     = r_size - SW'(1);
                        n_state    = (r_size == SW'(1)) ? htks_pkg::ST_IDLE
                                                        : htks_pkg::ST_POP_RD;
                    end
                end
            end
            htks_pkg::ST_POP_RD: begin
                ram_raddr = r_size[AW-1:0];
                n_state   = htks_pkg::ST_POP_LAST;
            end
            htks_pkg::ST_POP_LAST: begin
                n_ent   = ram_rdata;
                n_pos   = '0;
                n_state = htks_pkg::ST_SD_RDL;
            end
            default: n_state = htks_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= htks_pkg::ST_IDLE;
            r_size      <= '0;
            r_out_valid <= 1'b0;
            r_seed      <= htks_pkg::SEED_RESET;
            r_keep      <= htks_pkg::KEEP_RESET;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    htks_pkg::CFG_SEED: r_seed <= i_cfg_data;
                    default:            r_keep <= i_cfg_data[htks_pkg::KEEP_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_ent       <= n_ent;
        r_child     <= n_child;
        r_empty     <= n_empty;
        r_out_key   <= n_out_key;
        r_out_mask  <= n_out_mask;
        r_out_empty <= n_out_empty;
        if (hash_start) begin
            r_mask_in <= i_mask;
        end
        if (ram_we && (ram_waddr == '0)) begin
            r_root <= ram_wdata;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_result_key  = r_out_key;
    assign o_result_mask = r_out_mask;
    assign o_was_empty   = r_out_empty;

endmodule

### rtl/htks_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module htks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/htks_hash.sv
// Multi-cycle splitmix64 key unit on one shared 32x32 multiplier.
// Depends on htks_pkg.
module htks_hash (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [htks_pkg::KEY_W-1:0] i_value,
    output logic                      o_done,
    output logic [htks_pkg::KEY_W-1:0] o_key
);

    logic                      r_busy;
    logic                      r_done;
    logic [3:0]                r_step;
    logic [htks_pkg::KEY_W-1:0] r_a;
    logic [htks_pkg::KEY_W-1:0] r_acc;
    logic [htks_pkg::KEY_W-1:0] r_key;

    logic [htks_pkg::KEY_W-1:0] mul_b;
    logic [31:0]               op_a;
    logic [31:0]               op_b;
    logic [63:0]               prod;
    logic [1:0]                sub;

    always_comb begin
        mul_b = (r_step >= 4'd5) ? htks_pkg::MIX_MUL2 : htks_pkg::MIX_MUL1;
        sub   = (r_step >= 4'd5) ? 2'(r_step - 4'd5) : 2'(r_step - 4'd1);
        op_a  = (sub == 2'd2) ? r_a[63:32] : r_a[31:0];
        op_b  = (sub == 2'd1) ? mul_b[63:32] : mul_b[31:0];
        prod  = 64'(op_a) * 64'(op_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 4'd1;
                if (r_step == 4'd8) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_value + htks_pkg::MIX_ADD;
        end else if (r_busy) begin
            case (r_step)
                4'd0: r_a <= r_a ^ (r_a >> 30);
                4'd4: r_a <= r_acc ^ (r_acc >> 27);
                4'd8: r_key <= r_acc ^ (r_acc >> 31);
                default: begin
                    if (sub == 2'd0) begin
                        r_acc <= prod;
                    end else begin
                        r_acc <= r_acc + {prod[31:0], 32'b0};
                    end
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_key  = r_key;

endmodule

### rtl/htks_check.sv
// Port-level checker for the hashed top-k selector, bound to the top level.
// Depends on htks_pkg.
module htks_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [htks_pkg::KEY_W-1:0]     o_result_key,
    input logic [htks_pkg::MASK_BITS-1:0] o_result_mask,
    input logic                          o_was_empty
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_key)
            && $stable(o_result_mask) && $stable(o_was_empty))
        else $error("stalled item changed");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_was_empty |-> o_result_key == '0 && o_result_mask == '0)
        else $error("empty pop carries data");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item accepted in back-to-back cycles");

    a_reset_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind hashed_top_k_selector_top htks_check u_htks_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_result_key  (o_result_key),
    .o_result_mask (o_result_mask),
    .o_was_empty   (o_was_empty)
);

### tb/sv/tb_hashed_top_k_selector_checker.sv
// Scoreboard for the hashed top-k selector: watches the item and config channels,
// keeps its own max-heap copy and compares every popped result field by field.
// Depends on htks_pkg.
`timescale 1ns / 100ps
module tb_hashed_top_k_selector_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_operation,
    input  logic [htks_pkg::MASK_BITS-1:0] i_mask,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [htks_pkg::KEY_W-1:0]     i_result_key,
    input  logic [htks_pkg::MASK_BITS-1:0] i_result_mask,
    input  logic                           i_was_empty,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [htks_pkg::SEED_W-1:0]    i_cfg_data,
    output int                             o_errors,
    output int                             o_pending
);

    typedef struct packed {
        logic [htks_pkg::KEY_W-1:0]     key;
        logic [htks_pkg::MASK_BITS-1:0] mask;
        logic                           empty;
    } t_popped;

    logic [htks_pkg::KEY_W-1:0]     hk [htks_pkg::CAPACITY];
    logic [htks_pkg::MASK_BITS-1:0] hm [htks_pkg::CAPACITY];
    int                             hsize;
    logic [htks_pkg::SEED_W-1:0]    cur_seed;
    logic [htks_pkg::KEEP_W-1:0]    cur_keep;
    t_popped                        popped_q[$];
    int                             errors;

    assign o_errors  = errors;
    assign o_pending = popped_q.size();

    function automatic logic [htks_pkg::KEY_W-1:0] splitmix(
        input logic [htks_pkg::KEY_W-1:0] x
    );
        logic [htks_pkg::KEY_W-1:0] v;
        v = x + 64'h9e3779b97f4a7c15;
        v = (v ^ (v >> 30)) * 64'hbf58476d1ce4e5b9;
        v = (v ^ (v >> 27)) * 64'h94d049bb133111eb;
        return v ^ (v >> 31);
    endfunction

    function automatic bit smaller(
        input logic [htks_pkg::KEY_W-1:0]     ka,
        input logic [htks_pkg::MASK_BITS-1:0] ma,
        input logic [htks_pkg::KEY_W-1:0]     kb,
        input logic [htks_pkg::MASK_BITS-1:0] mb
    );
        return (ka != kb) ? (ka < kb) : (ma < mb);
    endfunction

    function automatic int keep_limit();
        if (cur_keep == 0) return 1;
        if (int'(cur_keep) > htks_pkg::CAPACITY) return htks_pkg::CAPACITY;
        return int'(cur_keep);
    endfunction

    task automatic sink_root();
        int                             p, l, b;
        logic [htks_pkg::KEY_W-1:0]     k;
        logic [htks_pkg::MASK_BITS-1:0] m;
        p = 0;
        k = hk[0];
        m = hm[0];
        forever begin
            l = 2 * p + 1;
            if (l >= hsize) break;
            b = l;
            if (l + 1 < hsize && smaller(hk[l], hm[l], hk[l+1], hm[l+1])) b = l + 1;
            if (!smaller(k, m, hk[b], hm[b])) break;
            hk[p] = hk[b];
            hm[p] = hm[b];
            p = b;
        end
        hk[p] = k;
        hm[p] = m;
    endtask

    task automatic rank_offer(input logic [htks_pkg::MASK_BITS-1:0] m);
        logic [htks_pkg::KEY_W-1:0] k;
        int                         p, par;
        k = splitmix({34'd0, m} ^ {1'b0, cur_seed});
        if (hsize < keep_limit()) begin
            p = hsize;
            hsize++;
            while (p > 0) begin
                par = (p - 1) / 2;
                if (!smaller(hk[par], hm[par], k, m)) break;
                hk[p] = hk[par];
                hm[p] = hm[par];
                p = par;
            end
            hk[p] = k;
            hm[p] = m;
        end else if (smaller(k, m, hk[0], hm[0])) begin
            hk[0] = k;
            hm[0] = m;
            sink_root();
        end
    endtask

    task automatic take_largest();
        t_popped e;
        if (hsize == 0) begin
            e = '{key: '0, mask: '0, empty: 1'b1};
        end else begin
            e = '{key: hk[0], mask: hm[0], empty: 1'b0};
            hsize--;
            if (hsize > 0) begin
                hk[0] = hk[hsize];
                hm[0] = hm[hsize];
                sink_root();
            end
        end
        popped_q.insert(popped_q.size(), e);
    endtask

    always @(posedge i_clk) begin
        t_popped e;
        if (!i_rst_n) begin
            hsize    = 0;
            cur_seed = htks_pkg::SEED_RESET;
            cur_keep = htks_pkg::KEEP_RESET;
            popped_q.delete();
            errors   = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (popped_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result key=%h mask=%h empty=%b",
                                 i_result_key, i_result_mask, i_was_empty);
                end else begin
                    e = popped_q.pop_front();
                    if (e.key !== i_result_key || e.mask !== i_result_mask ||
                        e.empty !== i_was_empty) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch exp key=%h mask=%h empty=%b ",
                                      "got key=%h mask=%h empty=%b"},
                                     e.key, e.mask, e.empty,
                                     i_result_key, i_result_mask, i_was_empty);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == htks_pkg::CFG_SEED) cur_seed = i_cfg_data;
                else cur_keep = i_cfg_data[htks_pkg::KEEP_W-1:0];
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_operation == htks_pkg::OP_OFFER) rank_offer(i_mask);
                else take_largest();
            end
        end
    end

endmodule

### tb/sv/tb_hashed_top_k_selector_top.sv
// Testbench top for the hashed top-k selector: clock, reset, config writes,
// directed and random items with idle and stall phases, and the verdict.
// Depends on htks_pkg, hashed_top_k_selector_top, tb_hashed_top_k_selector_checker.
`timescale 1ns / 100ps
module tb_hashed_top_k_selector_top;

    logic                           clk = 0;
    logic                           rst_n = 0;
    logic                           in_valid = 0;
    logic                           in_stall;
    logic                           operation = htks_pkg::OP_OFFER;
    logic [htks_pkg::MASK_BITS-1:0] mask = '0;
    logic                           out_valid;
    logic                           out_stall = 0;
    logic [htks_pkg::KEY_W-1:0]     result_key;
    logic [htks_pkg::MASK_BITS-1:0] result_mask;
    logic                           was_empty;
    logic                           cfg_valid = 0;
    logic                           cfg_ready;
    logic                           cfg_index = htks_pkg::CFG_SEED;
    logic [htks_pkg::SEED_W-1:0]    cfg_data = '0;
    int                             errors, pending;
    int                             send_idle = 0, recv_stall = 0;
    bit                             hold_off = 0;
    int                             cycles = 0;
    logic [htks_pkg::MASK_BITS-1:0] pool[16];

    localparam int LIMIT = 2_000_000;

    always begin
        #10 clk = 1;
        #10 clk = 0;
    end

    hashed_top_k_selector_top u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_operation(operation), .i_mask(mask),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_result_key(result_key), .o_result_mask(result_mask), .o_was_empty(was_empty),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    tb_hashed_top_k_selector_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_operation(operation), .i_mask(mask),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_result_key(result_key), .i_result_mask(result_mask), .i_was_empty(was_empty),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge clk) begin
        if (hold_off) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(99) < recv_stall);
    end

    task automatic send(input logic op, input logic [htks_pkg::MASK_BITS-1:0] m);
        @(negedge clk);
        while ($urandom_range(99) < send_idle) @(negedge clk);
        in_valid  <= 1'b1;
        operation <= op;
        mask      <= m;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic write_reg(input logic idx, input logic [htks_pkg::SEED_W-1:0] d);
        while (pending != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [htks_pkg::MASK_BITS-1:0] rand_mask();
        logic [htks_pkg::MASK_BITS-1:0] m;
        m = htks_pkg::MASK_BITS'($urandom());
        case ($urandom_range(3))
            0: m = pool[$urandom_range(15)];
            1: m = m & {htks_pkg::MASK_BITS{1'($urandom_range(1))}};
            default: ;
        endcase
        return m;
    endfunction

    task automatic random_items(input int n, input int pop_pct);
        repeat (n) begin
            if ($urandom_range(99) < pop_pct)
                send(htks_pkg::OP_POP, htks_pkg::MASK_BITS'($urandom()));
            else
                send(htks_pkg::OP_OFFER, rand_mask());
        end
    endtask

    initial begin
        foreach (pool[i]) pool[i] = htks_pkg::MASK_BITS'($urandom());
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send(htks_pkg::OP_POP, '1);
        send(htks_pkg::OP_OFFER, '0);
        send(htks_pkg::OP_OFFER, '1);
        send(htks_pkg::OP_OFFER, '0);
        send(htks_pkg::OP_OFFER, 30'h2aaaaaaa);
        send(htks_pkg::OP_POP, '0);
        send(htks_pkg::OP_POP, '0);
        send(htks_pkg::OP_POP, '0);
        send(htks_pkg::OP_POP, '0);
        send(htks_pkg::OP_POP, '0);
        write_reg(htks_pkg::CFG_KEEP, 63'd0);
        send(htks_pkg::OP_OFFER, 30'h15555555);
        send(htks_pkg::OP_OFFER, 30'h0000ffff);
        send(htks_pkg::OP_OFFER, '1);
        send(htks_pkg::OP_POP, '0);
        send(htks_pkg::OP_POP, '0);
        write_reg(htks_pkg::CFG_SEED, '0);
        write_reg(htks_pkg::CFG_KEEP, 63'h3fff);
        send(htks_pkg::OP_OFFER, 30'd1);
        send(htks_pkg::OP_OFFER, 30'd2);
        write_reg(htks_pkg::CFG_SEED, '1);
        send(htks_pkg::OP_OFFER, 30'd1);
        send(htks_pkg::OP_OFFER, 30'd3);
        write_reg(htks_pkg::CFG_KEEP, 63'd2);
        send(htks_pkg::OP_OFFER, 30'd7);
        send(htks_pkg::OP_POP, '0);
        send(htks_pkg::OP_POP, '0);
        send(htks_pkg::OP_POP, '0);
        send(htks_pkg::OP_POP, '0);

        write_reg(htks_pkg::CFG_KEEP, 63'd8);
        write_reg(htks_pkg::CFG_SEED, htks_pkg::SEED_W'({$urandom(), $urandom()}));
        random_items(130, 30);

        send_idle = 61;
        write_reg(htks_pkg::CFG_KEEP, 63'd1);
        random_items(90, 35);

        send_idle = 0;
        recv_stall = 61;
        write_reg(htks_pkg::CFG_KEEP, 63'd16);
        write_reg(htks_pkg::CFG_SEED, 63'h7fffffffffffffff);
        random_items(110, 40);

        send_idle = 32;
        recv_stall = 32;
        write_reg(htks_pkg::CFG_KEEP, 63'd8192);
        random_items(110, 30);

        send_idle = 0;
        recv_stall = 0;
        write_reg(htks_pkg::CFG_KEEP, 63'd5);
        fork
            begin
                hold_off = 1;
                repeat (2000) @(negedge clk);
                hold_off = 0;
            end
            random_items(60, 60);
        join
        random_items(40, 50);

        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
